// ===== rtl/core/bba_pkg.sv =====
// Package for the buddy block allocator: types, constants and states.
`timescale 1ns / 1ps

package bba_pkg;

  // Default tree depth and smallest block size.
  localparam int LEVELS_DEF = 12;
  localparam int MIN_BLOCK_SHIFT_DEF = 20;

  // Fixed field widths.
  localparam int ADDR_W = 48;
  localparam int SIZE_W = 32;
  localparam int RLVL_W = 4;
  // Width used for block size comparisons; covers any tree in range.
  localparam int CMP_W = 64;

  // Register reset values.
  localparam logic [RLVL_W-1:0] ROOT_LEVEL_RST = 4'd11;

  // Configuration register indexes.
  localparam logic CFG_REGION_BASE = 1'b0;
  localparam logic CFG_ROOT_LEVEL = 1'b1;

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] free_addr;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] alloc_addr;
    logic              ok;
  } out_t;

  // One tree node as held in the node memory.
  typedef struct packed {
    logic full;
    logic split;
  } node_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_SPLIT_LO,
    ST_SPLIT_HI,
    ST_RET,
    ST_SIB,
    ST_MERGE,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/bba_node_ram.sv =====
// Node memory holding the full and split bits, with a clearing pass after reset.
`timescale 1ns / 1ps

module bba_node_ram #(
  parameter int LEVELS = bba_pkg::LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [LEVELS-1:0]  rd_addr,
  output bba_pkg::node_t     rd_data,
  input  logic               wr_en,
  input  logic [LEVELS-1:0]  wr_addr,
  input  bba_pkg::node_t     wr_data,
  output logic               busy
);

  localparam int NODES = 1 << LEVELS;

  bba_pkg::node_t mem [NODES];
  logic [LEVELS:0] clr_cnt;

  logic                we;
  logic [LEVELS-1:0]   wa;
  bba_pkg::node_t      wd;

  assign busy = ~clr_cnt[LEVELS];

  // The clearing pass takes over the write port until every entry is zero.
  always_comb begin
    if (busy) begin
      we = 1'b1;
      wa = clr_cnt[LEVELS-1:0];
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  // Clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Memory array with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/buddy_block_allocator_core.sv =====
// Buddy block allocator top level: request handshake, tree walk sequencer and registers.
`timescale 1ns / 1ps

// Each request walks the node tree one node at a time through a single node
// memory whose reads are registered. Descending takes a read, then an
// evaluation, at each level; splitting a free node adds writes that clear its
// children, and climbing back takes a sibling read, then a parent write-back,
// at each level. An allocation that fails on its first path backtracks and
// tries further nodes; a free walks down to its block and back to the root.
// Oversized allocations and frees outside the region skip the walk entirely.
// After reset the node memory is cleared entry by entry, during which no
// request is taken; configuration writes are accepted at all times.

module buddy_block_allocator_core #(
  parameter int LEVELS = bba_pkg::LEVELS_DEF,
  parameter int MIN_BLOCK_SHIFT = bba_pkg::MIN_BLOCK_SHIFT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bba_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bba_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [bba_pkg::ADDR_W-1:0]  cfg_data
);

  localparam int LVW = (LEVELS > 2) ? $clog2(LEVELS) : 1;
  localparam int AW = bba_pkg::ADDR_W;
  localparam int CW = bba_pkg::CMP_W;

  // Configuration registers.
  logic [AW-1:0]                  region_base;
  logic [bba_pkg::RLVL_W-1:0]     root_level;

  // Walk state.
  bba_pkg::state_t state, state_next;
  logic                mode;
  logic [LEVELS-1:0]   idx;
  logic [LVW-1:0]      lvl;
  logic [AW-1:0]       off;
  logic [AW-1:0]       got;
  logic [AW-1:0]       rel;
  logic [bba_pkg::SIZE_W-1:0] size;
  logic                done;
  logic                my_full;
  logic                my_split;

  // Memory port.
  logic [LEVELS-1:0]   rd_addr;
  bba_pkg::node_t      rd_data;
  logic                wr_en;
  logic [LEVELS-1:0]   wr_addr;
  bba_pkg::node_t      wr_data;
  logic                clr_busy;

  // Derived values.
  logic [LVW-1:0]      eff_lvl;
  logic [CW-1:0]       root_size;
  logic [CW-1:0]       half;
  logic [AW-1:0]       csize;
  logic [AW-1:0]       rel_sh;
  logic [AW:0]         fdiff;
  logic                in_region;
  logic                oversize;
  logic                take_whole;
  bba_pkg::node_t      parent_val;
  logic                in_acc;
  logic                out_free;

  bba_node_ram #(
    .LEVELS(LEVELS)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .busy    (clr_busy)
  );

  // Effective root level and block sizes at the current level.
  always_comb begin
    if (int'(root_level) > LEVELS - 1) begin
      eff_lvl = LVW'(LEVELS - 1);
    end else begin
      eff_lvl = LVW'(root_level);
    end
    root_size = CW'(1) << (MIN_BLOCK_SHIFT + int'(eff_lvl));
    half = CW'(1) << (MIN_BLOCK_SHIFT + int'(lvl) - 1);
    csize = AW'(1) << (MIN_BLOCK_SHIFT + int'(lvl));
    rel_sh = rel >> (MIN_BLOCK_SHIFT + int'(lvl) - 1);
    fdiff = {1'b0, in_data.free_addr} - {1'b0, region_base};
    in_region = ~fdiff[AW] && (CW'(fdiff[AW-1:0]) < root_size);
    oversize = CW'(in_data.req_size) > root_size;
    take_whole = CW'(size) > half;
  end

  // Parent value after one of its children has been settled.
  always_comb begin
    if (mode == bba_pkg::MODE_FREE && !my_full && !my_split &&
        !rd_data.full && !rd_data.split) begin
      parent_val = '0;
    end else begin
      parent_val.full = my_full & rd_data.full;
      parent_val.split = 1'b1;
    end
  end

  assign out_free = ~out_valid | ~out_stall;
  assign in_stall = clr_busy | (state != bba_pkg::ST_IDLE);
  assign in_acc = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.mode == bba_pkg::MODE_ALLOC) begin
            state_next = oversize ? bba_pkg::ST_DONE : bba_pkg::ST_READ;
          end else begin
            state_next = in_region ? bba_pkg::ST_READ : bba_pkg::ST_DONE;
          end
        end
      end
      bba_pkg::ST_READ: state_next = bba_pkg::ST_EVAL;
      bba_pkg::ST_EVAL: begin
        if (mode == bba_pkg::MODE_ALLOC) begin
          if (rd_data.full || lvl == '0 || take_whole) begin
            state_next = bba_pkg::ST_RET;
          end else if (rd_data.split) begin
            state_next = bba_pkg::ST_READ;
          end else begin
            state_next = bba_pkg::ST_SPLIT_LO;
          end
        end else begin
          if (lvl != '0 && rd_data.split) begin
            state_next = bba_pkg::ST_READ;
          end else begin
            state_next = bba_pkg::ST_RET;
          end
        end
      end
      bba_pkg::ST_SPLIT_LO: state_next = bba_pkg::ST_SPLIT_HI;
      bba_pkg::ST_SPLIT_HI: state_next = bba_pkg::ST_READ;
      bba_pkg::ST_RET: begin
        if (idx == LEVELS'(1)) begin
          state_next = bba_pkg::ST_DONE;
        end else if (mode == bba_pkg::MODE_ALLOC && !done && !idx[0]) begin
          state_next = bba_pkg::ST_READ;
        end else begin
          state_next = bba_pkg::ST_SIB;
        end
      end
      bba_pkg::ST_SIB: state_next = bba_pkg::ST_MERGE;
      bba_pkg::ST_MERGE: state_next = bba_pkg::ST_RET;
      bba_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      default: state_next = bba_pkg::ST_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    rd_addr = idx;
    wr_en = 1'b0;
    wr_addr = idx;
    wr_data = '0;
    unique case (state)
      bba_pkg::ST_EVAL: begin
        if (mode == bba_pkg::MODE_ALLOC) begin
          if (rd_data.full) begin
            wr_en = 1'b0;
          end else if (lvl == '0) begin
            wr_en = 1'b1;
            wr_data = '{full: 1'b1, split: rd_data.split};
          end else if (take_whole) begin
            wr_en = ~rd_data.split;
            wr_data = '{full: 1'b1, split: 1'b0};
          end else if (!rd_data.split) begin
            wr_en = 1'b1;
            wr_data = '{full: 1'b0, split: 1'b1};
          end
        end else if (!(lvl != '0 && rd_data.split)) begin
          wr_en = 1'b1;
          wr_data = '{full: 1'b0, split: rd_data.split};
        end
      end
      bba_pkg::ST_SPLIT_LO: begin
        wr_en = 1'b1;
        wr_addr = {idx[LEVELS-2:0], 1'b0};
      end
      bba_pkg::ST_SPLIT_HI: begin
        wr_en = 1'b1;
        wr_addr = {idx[LEVELS-2:0], 1'b1};
      end
      bba_pkg::ST_SIB: begin
        rd_addr = {idx[LEVELS-1:1], ~idx[0]};
      end
      bba_pkg::ST_MERGE: begin
        wr_en = 1'b1;
        wr_addr = idx >> 1;
        wr_data = parent_val;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::ST_IDLE;
      out_valid <= 1'b0;
      region_base <= '0;
      root_level <= bba_pkg::ROOT_LEVEL_RST;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bba_pkg::CFG_REGION_BASE) begin
          region_base <= cfg_data;
        end else begin
          root_level <= cfg_data[bba_pkg::RLVL_W-1:0];
        end
      end
      if (state == bba_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      bba_pkg::ST_IDLE: begin
        mode <= in_data.mode;
        size <= in_data.req_size;
        rel <= fdiff[AW-1:0];
        idx <= LEVELS'(1);
        lvl <= eff_lvl;
        off <= '0;
        done <= 1'b0;
      end
      bba_pkg::ST_EVAL: begin
        if (mode == bba_pkg::MODE_ALLOC) begin
          if (rd_data.full) begin
            done <= 1'b0;
            my_full <= 1'b1;
          end else if (lvl == '0 || take_whole) begin
            done <= (lvl == '0) | ~rd_data.split;
            my_full <= (lvl == '0) | ~rd_data.split;
            got <= off;
          end else if (rd_data.split) begin
            idx <= {idx[LEVELS-2:0], 1'b0};
            lvl <= lvl - 1'b1;
          end
        end else begin
          if (lvl != '0 && rd_data.split) begin
            idx <= {idx[LEVELS-2:0], rel_sh[0]};
            lvl <= lvl - 1'b1;
          end else begin
            my_full <= 1'b0;
            my_split <= rd_data.split;
          end
        end
      end
      bba_pkg::ST_SPLIT_HI: begin
        idx <= {idx[LEVELS-2:0], 1'b0};
        lvl <= lvl - 1'b1;
      end
      bba_pkg::ST_RET: begin
        if (idx != LEVELS'(1) && mode == bba_pkg::MODE_ALLOC && !done && !idx[0]) begin
          idx <= idx + 1'b1;
          off <= off + csize;
        end
      end
      bba_pkg::ST_MERGE: begin
        my_full <= parent_val.full;
        my_split <= parent_val.split;
        idx <= idx >> 1;
        lvl <= lvl + 1'b1;
        off <= off & ~csize;
      end
      bba_pkg::ST_DONE: begin
        if (out_free) begin
          out_data.ok <= (mode == bba_pkg::MODE_FREE) | done;
          out_data.alloc_addr <= (mode == bba_pkg::MODE_ALLOC && done) ?
                                 region_base + got : '0;
        end
      end
      default: begin
        done <= done;
      end
    endcase
  end

endmodule
